>>> rtl/thw_pkg.sv
// Shared types and constants for the task heartbeat watchdog.
// Holds the request and response word layouts and the control word between
// the sequencer and the datapath. No dependencies.
package thw_pkg;

   // Default slot count and the cap on events reported by a single check.
   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_EVENTS    = 8;
   localparam int CNT_W         = 4;

   // Default timeouts loaded at reset.
   localparam logic [31:0] TIMEOUT_DEFAULT = 32'd1000;
   localparam logic [31:0] TIMEOUT_SLOT1   = 32'd3000;
   localparam logic [31:0] TIMEOUT_SLOT2   = 32'd2000;

   // Request modes.
   localparam logic [1:0] MODE_BEAT    = 2'd0;
   localparam logic [1:0] MODE_SET_IVL = 2'd1;
   localparam logic [1:0] MODE_CHECK   = 2'd2;

   // Event kinds.
   localparam logic KIND_HUNG      = 1'b0;
   localparam logic KIND_RECOVERED = 1'b1;

   // Datapath operations selected by the microcode.
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_BEAT  = 3'd1;
   localparam logic [2:0] OP_IVL   = 3'd2;
   localparam logic [2:0] OP_SCAN  = 3'd3;
   localparam logic [2:0] OP_FLUSH = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  slot;
      logic [31:0] now_tick;
      logic [31:0] interval_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] event_slot;
      logic       event_kind;
      logic       last;
   } rsp_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic       load;
      logic [2:0] op;
   } ctrl_type;

endpackage

>>> rtl/task_heartbeat_watchdog_unit.sv
// Task heartbeat watchdog, top level.
// Beat and set-interval words are accepted, then written; a mode 3 word is only accepted.
// A check is accepted, scans one slot per cycle while the output register is not held
// by rsp_ready low, and then flushes.
// One word is in work at a time. Reset clears the started and hung flags and
// loads the default timeouts at once; there is no clearing pass.
module task_heartbeat_watchdog_unit #(
   parameter int SLOTS = thw_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  thw_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output thw_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   thw_pkg::ctrl_type ctrl;
   logic [IDX_W-1:0]  idx;
   logic              stall;

   // Sequencer: step counter, control ROM and slot counter.
   thw_sequencer #(
      .SLOTS (SLOTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .stall     (stall),
      .req_ready (req_ready),
      .ctrl      (ctrl),
      .idx       (idx)
   );

   // Datapath: slot state and event output.
   thw_datapath #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .ctrl      (ctrl),
      .idx       (idx),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .stall     (stall)
   );

endmodule

>>> rtl/thw_sequencer.sv
// Microcode sequencer for the heartbeat watchdog: step counter, control ROM
// and slot index counter. Depends on thw_pkg.
module thw_sequencer #(
   parameter int SLOTS = thw_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_mode,
   input  logic               stall,
   output logic               req_ready,
   output thw_pkg::ctrl_type  ctrl,
   output logic [IDX_W-1:0]   idx
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

   // Step codes.
   localparam logic [2:0] STEP_FETCH = 3'd0;
   localparam logic [2:0] STEP_BEAT  = 3'd1;
   localparam logic [2:0] STEP_IVL   = 3'd2;
   localparam logic [2:0] STEP_SCAN  = 3'd3;
   localparam logic [2:0] STEP_FLUSH = 3'd4;

   // Jump conditions.
   localparam logic [1:0] COND_ALWAYS   = 2'd0;
   localparam logic [1:0] COND_MODE     = 2'd1;
   localparam logic [1:0] COND_SCAN_END = 2'd2;

   typedef struct packed {
      logic       ready;
      logic [2:0] op;
      logic [1:0] cond;
      logic [2:0] target;
   } ucode_type;

   logic [2:0]       step_ff, step_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   ucode_type        uc;

   // Control ROM: one word per step.
   always_comb begin
      case (step_ff)
         STEP_FETCH: uc = '{1'b1, thw_pkg::OP_NONE,  COND_MODE,     STEP_FETCH};
         STEP_BEAT:  uc = '{1'b0, thw_pkg::OP_BEAT,  COND_ALWAYS,   STEP_FETCH};
         STEP_IVL:   uc = '{1'b0, thw_pkg::OP_IVL,   COND_ALWAYS,   STEP_FETCH};
         STEP_SCAN:  uc = '{1'b0, thw_pkg::OP_SCAN,  COND_SCAN_END, STEP_FLUSH};
         STEP_FLUSH: uc = '{1'b0, thw_pkg::OP_FLUSH, COND_ALWAYS,   STEP_FETCH};
         default:    uc = '{1'b0, thw_pkg::OP_NONE,  COND_ALWAYS,   STEP_FETCH};
      endcase
   end

   // Next step and slot index; everything holds while the datapath stalls.
   always_comb begin
      step_in = step_ff;
      idx_in  = idx_ff;
      if (!stall) begin
         case (uc.cond)
            COND_ALWAYS: begin
               step_in = uc.target;
               idx_in  = '0;
            end
            COND_MODE: begin
               if (req_valid) begin
                  case (req_mode)
                     thw_pkg::MODE_BEAT:    step_in = STEP_BEAT;
                     thw_pkg::MODE_SET_IVL: step_in = STEP_IVL;
                     thw_pkg::MODE_CHECK:   step_in = STEP_SCAN;
                     default:               step_in = uc.target;
                  endcase
               end
               idx_in = '0;
            end
            COND_SCAN_END: begin
               if (idx_ff == IDX_LAST) begin
                  step_in = uc.target;
                  idx_in  = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            default: begin
               step_in = STEP_FETCH;
               idx_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
         idx_ff  <= '0;
      end else begin
         step_ff <= step_in;
         idx_ff  <= idx_in;
      end
   end

   assign req_ready = uc.ready;
   assign ctrl.load = req_valid & uc.ready;
   assign ctrl.op   = uc.op;
   assign idx       = idx_ff;

endmodule

>>> rtl/thw_datapath.sv
// Datapath of the heartbeat watchdog: slot state, age compare, pending event
// word and output register. Depends on thw_pkg.
module thw_datapath #(
   parameter int SLOTS = thw_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  thw_pkg::req_type   req,
   input  thw_pkg::ctrl_type  ctrl,
   input  logic [IDX_W-1:0]   idx,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output thw_pkg::rsp_type   rsp,
   output logic               stall
);

   localparam logic [thw_pkg::CNT_W-1:0] CNT_MAX = thw_pkg::CNT_W'(thw_pkg::MAX_EVENTS);

   thw_pkg::req_type           req_ff;
   logic [31:0]                beat_time_ff [SLOTS];
   logic [31:0]                timeout_ff   [SLOTS];
   logic [SLOTS-1:0]           started_ff;
   logic [SLOTS-1:0]           hung_ff;
   logic                       pend_valid_ff;
   thw_pkg::rsp_type           pend_ff;
   logic [thw_pkg::CNT_W-1:0]  cnt_ff;
   logic                       rsp_valid_ff;
   thw_pkg::rsp_type           rsp_ff;

   logic [31:0]      slot_ext;
   logic [31:0]      idx_ext;
   logic             slot_ok;
   logic [IDX_W-1:0] waddr;
   logic [31:0]      age;
   logic             hung_now;
   logic             evt;
   logic             take;
   logic             is_scan;
   logic             is_flush;
   logic             out_free;
   logic             push;
   thw_pkg::rsp_type new_word;

   // Write address of a beat or interval word and its range check.
   assign slot_ext = 32'(req_ff.slot);
   assign slot_ok  = slot_ext < 32'(SLOTS);
   assign waddr    = slot_ext[IDX_W-1:0];

   // Wrapping age of the scanned slot against its timeout.
   assign age      = req_ff.now_tick - beat_time_ff[idx];
   assign hung_now = age > timeout_ff[idx];

   // A status change on a started slot is an event; only the first MAX_EVENTS count.
   assign is_scan  = ctrl.op == thw_pkg::OP_SCAN;
   assign is_flush = ctrl.op == thw_pkg::OP_FLUSH;
   assign evt      = started_ff[idx] && (hung_now != hung_ff[idx]);
   assign take     = is_scan && evt && (cnt_ff < CNT_MAX);

   assign idx_ext             = 32'(idx);
   assign new_word.event_slot = idx_ext[2:0];
   assign new_word.event_kind = hung_now ? thw_pkg::KIND_HUNG : thw_pkg::KIND_RECOVERED;
   assign new_word.last       = 1'b0;

   // The pending word moves out when a newer event is taken or at the flush.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push     = (take || is_flush) && pend_valid_ff && out_free;
   assign stall    = (take || is_flush) && pend_valid_ff && !out_free;

   // Request word register.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req;
      end
   end

   // Beat times.
   always_ff @(posedge clock) begin
      if (ctrl.op == thw_pkg::OP_BEAT && slot_ok) begin
         beat_time_ff[waddr] <= req_ff.now_tick;
      end
   end

   // Timeouts, with their default values at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (i == 1) begin
               timeout_ff[i] <= thw_pkg::TIMEOUT_SLOT1;
            end else if (i == 2) begin
               timeout_ff[i] <= thw_pkg::TIMEOUT_SLOT2;
            end else begin
               timeout_ff[i] <= thw_pkg::TIMEOUT_DEFAULT;
            end
         end
      end else if (ctrl.op == thw_pkg::OP_IVL && slot_ok && req_ff.interval_ms != '0) begin
         timeout_ff[waddr] <= req_ff.interval_ms;
      end
   end

   // Started and hung flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= '0;
         hung_ff    <= '0;
      end else begin
         if (ctrl.op == thw_pkg::OP_BEAT && slot_ok) begin
            started_ff[waddr] <= 1'b1;
         end
         if (is_scan && !stall && started_ff[idx]) begin
            hung_ff[idx] <= hung_now;
         end
      end
   end

   // Pending event word and the count of events taken by this check.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (ctrl.load) begin
            cnt_ff <= '0;
         end else if (take && !stall) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (take && !stall) begin
            pend_valid_ff <= 1'b1;
         end else if (is_flush && push) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && !stall) begin
         pend_ff <= new_word;
      end
   end

   // Output register; the word sent by the flush closes the check.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ff.event_slot <= pend_ff.event_slot;
         rsp_ff.event_kind <= pend_ff.event_kind;
         rsp_ff.last       <= is_flush;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("event count above cap");

   a_hung_started: assert property (@(posedge clock) disable iff (reset)
      (hung_ff & ~started_ff) == '0)
      else $error("hung flag set on a slot never beaten");

   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      (is_flush && !stall) |=> !pend_valid_ff)
      else $error("pending word left after flush");

   a_stall_scope: assert property (@(posedge clock) disable iff (reset)
      (!is_scan && !is_flush) |-> !stall)
      else $error("stall outside scan or flush");
`endif

endmodule
